// ----- design/mmst_pkg.sv -----
package mmst_pkg;

    localparam int MAX_CITIES = 32;
    localparam int EDGE_DEPTH = MAX_CITIES * (MAX_CITIES + 1) / 2;

    // node numbers 0..MAX_CITIES fit the 6-bit city fields
    localparam int NODE_W  = 6;
    localparam int ENDS_W  = 2 * NODE_W;
    localparam int IJ_W    = NODE_W + 1;
    localparam int CNT_W   = $clog2(MAX_CITIES + 1);
    localparam int CITY_AW = (MAX_CITIES > 1) ? $clog2(MAX_CITIES) : 1;
    localparam int EDGE_AW = $clog2(EDGE_DEPTH);
    localparam int M_W     = $clog2(EDGE_DEPTH + 1);
    localparam int PAR_DEPTH = MAX_CITIES + 1;

    localparam int XY_W   = 20;
    localparam int VAL_W  = 30;
    localparam int SUM_W  = VAL_W + 1;
    localparam int DIST_W = XY_W + 1;
    localparam int W_W    = SUM_W + DIST_W;
    localparam int COST_W = 58;
    localparam int CITY_W = 2 * XY_W + 2 * VAL_W;
    localparam int EDGE_W = W_W + ENDS_W;

    typedef enum logic [1:0] {
        KIND_STATION = 2'd0,
        KIND_WIRE    = 2'd1,
        KIND_TOTAL   = 2'd2
    } t_kind;

endpackage

// ----- design/mmst_if.sv -----
interface mmst_city_if;
    logic        valid;
    logic        ready;
    logic [19:0] coord_x;
    logic [19:0] coord_y;
    logic [29:0] station_cost;
    logic [29:0] wire_rate;
    logic        last_city;

    modport source (output valid, coord_x, coord_y, station_cost, wire_rate, last_city,
                    input ready);
    modport sink   (input valid, coord_x, coord_y, station_cost, wire_rate, last_city,
                    output ready);
endinterface

interface mmst_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [5:0]  city_a;
    logic [5:0]  city_b;
    logic [57:0] cost;
    logic        final_res;

    modport source (output valid, kind, city_a, city_b, cost, final_res, input ready);
    modport sink   (input valid, kind, city_a, city_b, cost, final_res, output ready);
endinterface

// ----- design/mmst_ram.sv -----
module mmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/manhattan_mst_with_virtual_source.sv -----
// Channel   Dir  Beat
// i_city    in   one city: coordinates, station cost, wire rate, last flag
// o_res     out  one accepted edge (station or wire), then the total cost
//
// Loading takes one city per cycle. After the last city the run builds all
// edges (a station edge is read and written, a wire edge passes through the
// city memory and the multiplier), writes n+1 parent entries, then does one
// selection pass over the edge memory per edge plus a parent-memory read for
// each hop of each root search. i_city is held off during the run.
// Reset is synchronous and active low; the memories need no clearing.
// A stalled o_res holds the run at the next emitted beat.
module manhattan_mst_with_virtual_source (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mmst_city_if.sink      i_city,
    mmst_res_if.source     o_res
);

    typedef enum logic [3:0] {
        S_LOAD, S_ST_RD, S_ST_WR, S_PR_CHK, S_PR_RA, S_PR_RB, S_PR_MUL, S_PR_WR,
        S_PAR, S_SCAN, S_F_RD, S_F_CHK, S_UNION, S_TOTAL
    } t_state;

    t_state r_state;
    logic [mmst_pkg::CNT_W-1:0]  r_count;
    logic [mmst_pkg::IJ_W-1:0]   r_n, r_i, r_j;
    logic [mmst_pkg::M_W-1:0]    r_m, r_k, r_rd_idx, r_bidx, r_lidx;
    logic [mmst_pkg::XY_W-1:0]   r_xa, r_ya;
    logic [mmst_pkg::VAL_W-1:0]  r_ra;
    logic [mmst_pkg::SUM_W-1:0]  r_sum;
    logic [mmst_pkg::DIST_W-1:0] r_dist;
    logic [mmst_pkg::W_W-1:0]    r_w, r_bw, r_lw;
    logic [mmst_pkg::ENDS_W-1:0] r_bends;
    logic                        r_rd_v, r_have_best, r_have_last, r_which;
    logic [mmst_pkg::NODE_W-1:0] r_node, r_root_a, r_root_b;
    logic [mmst_pkg::COST_W-1:0] r_total;
    logic                        r_ov, r_ofin;
    mmst_pkg::t_kind             r_okind;
    logic [mmst_pkg::NODE_W-1:0] r_oa, r_ob;
    logic [mmst_pkg::COST_W-1:0] r_ocost;

    logic                          city_we;
    logic [mmst_pkg::CITY_AW-1:0]  city_raddr;
    logic [mmst_pkg::CITY_W-1:0]   city_rdata;
    logic                          edge_we;
    logic [mmst_pkg::EDGE_W-1:0]   edge_wdata, edge_rdata;
    logic                          par_we;
    logic [mmst_pkg::NODE_W-1:0]   par_waddr, par_wdata, par_rdata;

    logic                          in_acc, out_free, after_last, before_best;
    logic [mmst_pkg::W_W-1:0]      e_w;
    logic [mmst_pkg::XY_W-1:0]     rb_x, rb_y;
    logic [mmst_pkg::VAL_W-1:0]    rb_st, rb_rate;

    assign in_acc   = i_city.valid && i_city.ready;
    assign out_free = !r_ov || o_res.ready;
    assign i_city.ready = (r_state == S_LOAD);

    assign {rb_x, rb_y, rb_st, rb_rate} = city_rdata;
    assign e_w = edge_rdata[mmst_pkg::EDGE_W-1:mmst_pkg::ENDS_W];

    // order against the last taken edge and the best one of this pass
    assign after_last = !r_have_last || (e_w > r_lw) || ((e_w == r_lw) && (r_rd_idx > r_lidx));
    assign before_best = !r_have_best || (e_w < r_bw);

    // memory port control
    always_comb begin
        city_we    = in_acc && (r_count < mmst_pkg::CNT_W'(mmst_pkg::MAX_CITIES));
        city_raddr = (r_state == S_PR_RA) ? mmst_pkg::CITY_AW'(r_j - 1'b1)
                                          : mmst_pkg::CITY_AW'(r_i - 1'b1);
        edge_we    = (r_state == S_ST_WR) || (r_state == S_PR_WR);
        if (r_state == S_ST_WR) begin
            edge_wdata = {mmst_pkg::W_W'(rb_st), mmst_pkg::NODE_W'(0),
                          mmst_pkg::NODE_W'(r_i)};
        end else begin
            edge_wdata = {r_w, mmst_pkg::NODE_W'(r_i), mmst_pkg::NODE_W'(r_j)};
        end
        par_we    = 1'b0;
        par_waddr = mmst_pkg::NODE_W'(r_k);
        par_wdata = mmst_pkg::NODE_W'(r_k);
        if (r_state == S_PAR) begin
            par_we = 1'b1;
        end else if (r_state == S_UNION && r_root_a != r_root_b && out_free) begin
            par_we    = 1'b1;
            par_waddr = r_root_a;
            par_wdata = r_root_b;
        end
    end

    mmst_ram #(.WIDTH(mmst_pkg::CITY_W), .DEPTH(mmst_pkg::MAX_CITIES),
               .AW(mmst_pkg::CITY_AW)) u_city_mem (
        .i_clk   (i_clk),
        .i_we    (city_we),
        .i_waddr (r_count[mmst_pkg::CITY_AW-1:0]),
        .i_wdata ({i_city.coord_x, i_city.coord_y, i_city.station_cost, i_city.wire_rate}),
        .i_raddr (city_raddr),
        .o_rdata (city_rdata)
    );

    mmst_ram #(.WIDTH(mmst_pkg::EDGE_W), .DEPTH(mmst_pkg::EDGE_DEPTH),
               .AW(mmst_pkg::EDGE_AW)) u_edge_mem (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (r_m[mmst_pkg::EDGE_AW-1:0]),
        .i_wdata (edge_wdata),
        .i_raddr (r_k[mmst_pkg::EDGE_AW-1:0]),
        .o_rdata (edge_rdata)
    );

    mmst_ram #(.WIDTH(mmst_pkg::NODE_W), .DEPTH(mmst_pkg::PAR_DEPTH),
               .AW(mmst_pkg::NODE_W)) u_parent_mem (
        .i_clk   (i_clk),
        .i_we    (par_we),
        .i_waddr (par_waddr),
        .i_wdata (par_wdata),
        .i_raddr (r_node),
        .o_rdata (par_rdata)
    );

    // sequencer: load, build edges, select in order, union-find, emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_total     <= '0;
            r_ov        <= 1'b0;
            r_rd_v      <= 1'b0;
            r_have_best <= 1'b0;
            r_have_last <= 1'b0;
        end else begin
            if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (in_acc) begin
                        if (city_we) begin
                            r_count <= r_count + 1'b1;
                        end
                        if (i_city.last_city) begin
                            r_n     <= city_we ? mmst_pkg::IJ_W'(r_count + 1'b1)
                                               : mmst_pkg::IJ_W'(r_count);
                            r_i     <= mmst_pkg::IJ_W'(1);
                            r_m     <= '0;
                            r_state <= S_ST_RD;
                        end
                    end
                end
                S_ST_RD: begin
                    if (r_i > r_n) begin
                        r_i     <= mmst_pkg::IJ_W'(1);
                        r_j     <= mmst_pkg::IJ_W'(2);
                        r_state <= S_PR_CHK;
                    end else begin
                        r_state <= S_ST_WR;
                    end
                end
                S_ST_WR: begin
                    r_m     <= r_m + 1'b1;
                    r_i     <= r_i + 1'b1;
                    r_state <= S_ST_RD;
                end
                S_PR_CHK: begin
                    if (r_j > r_n) begin
                        if (r_i + 1'b1 >= r_n) begin
                            r_k     <= '0;
                            r_state <= S_PAR;
                        end else begin
                            r_i <= r_i + 1'b1;
                            r_j <= r_i + 2'd2;
                        end
                    end else begin
                        r_state <= S_PR_RA;
                    end
                end
                S_PR_RA: begin
                    r_xa    <= rb_x;
                    r_ya    <= rb_y;
                    r_ra    <= rb_rate;
                    r_state <= S_PR_RB;
                end
                S_PR_RB: begin
                    r_sum  <= mmst_pkg::SUM_W'(r_ra) + mmst_pkg::SUM_W'(rb_rate);
                    r_dist <= mmst_pkg::DIST_W'((r_xa > rb_x) ? r_xa - rb_x : rb_x - r_xa)
                            + mmst_pkg::DIST_W'((r_ya > rb_y) ? r_ya - rb_y : rb_y - r_ya);
                    r_state <= S_PR_MUL;
                end
                S_PR_MUL: begin
                    r_w     <= mmst_pkg::W_W'(r_sum) * mmst_pkg::W_W'(r_dist);
                    r_state <= S_PR_WR;
                end
                S_PR_WR: begin
                    r_m     <= r_m + 1'b1;
                    r_j     <= r_j + 1'b1;
                    r_state <= S_PR_CHK;
                end
                S_PAR: begin
                    if (r_k == mmst_pkg::M_W'(r_n)) begin
                        r_k         <= '0;
                        r_rd_v      <= 1'b0;
                        r_have_best <= 1'b0;
                        r_have_last <= 1'b0;
                        r_state     <= S_SCAN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_SCAN: begin
                    if (r_k < r_m) begin
                        r_rd_v   <= 1'b1;
                        r_rd_idx <= r_k;
                        r_k      <= r_k + 1'b1;
                    end else begin
                        r_rd_v <= 1'b0;
                    end
                    if (r_rd_v && after_last && before_best) begin
                        r_have_best <= 1'b1;
                        r_bw        <= e_w;
                        r_bidx      <= r_rd_idx;
                        r_bends     <= edge_rdata[mmst_pkg::ENDS_W-1:0];
                    end
                    if (r_k >= r_m && !r_rd_v) begin
                        if (r_have_best) begin
                            r_have_last <= 1'b1;
                            r_lw        <= r_bw;
                            r_lidx      <= r_bidx;
                            r_node      <= r_bends[mmst_pkg::ENDS_W-1:mmst_pkg::NODE_W];
                            r_which     <= 1'b0;
                            r_state     <= S_F_RD;
                        end else begin
                            r_state <= S_TOTAL;
                        end
                    end
                end
                S_F_RD: begin
                    r_state <= S_F_CHK;
                end
                S_F_CHK: begin
                    if (par_rdata == r_node) begin
                        if (!r_which) begin
                            r_root_a <= r_node;
                            r_node   <= r_bends[mmst_pkg::NODE_W-1:0];
                            r_which  <= 1'b1;
                            r_state  <= S_F_RD;
                        end else begin
                            r_root_b <= r_node;
                            r_state  <= S_UNION;
                        end
                    end else begin
                        r_node  <= par_rdata;
                        r_state <= S_F_RD;
                    end
                end
                S_UNION: begin
                    if (r_root_a == r_root_b) begin
                        r_k         <= '0;
                        r_have_best <= 1'b0;
                        r_state     <= S_SCAN;
                    end else if (out_free) begin
                        r_total <= r_total + mmst_pkg::COST_W'(r_bw);
                        r_ov    <= 1'b1;
                        r_ofin  <= 1'b0;
                        r_ocost <= mmst_pkg::COST_W'(r_bw);
                        if (r_bends[mmst_pkg::ENDS_W-1:mmst_pkg::NODE_W] == '0) begin
                            r_okind <= mmst_pkg::KIND_STATION;
                            r_oa    <= r_bends[mmst_pkg::NODE_W-1:0];
                            r_ob    <= '0;
                        end else begin
                            r_okind <= mmst_pkg::KIND_WIRE;
                            r_oa    <= r_bends[mmst_pkg::ENDS_W-1:mmst_pkg::NODE_W];
                            r_ob    <= r_bends[mmst_pkg::NODE_W-1:0];
                        end
                        r_k         <= '0;
                        r_have_best <= 1'b0;
                        r_state     <= S_SCAN;
                    end
                end
                S_TOTAL: begin
                    if (out_free) begin
                        r_ov    <= 1'b1;
                        r_ofin  <= 1'b1;
                        r_okind <= mmst_pkg::KIND_TOTAL;
                        r_oa    <= '0;
                        r_ob    <= '0;
                        r_ocost <= r_total;
                        r_count <= '0;
                        r_total <= '0;
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.kind      = r_okind;
    assign o_res.city_a    = r_oa;
    assign o_res.city_b    = r_ob;
    assign o_res.cost      = r_ocost;
    assign o_res.final_res = r_ofin;

    a_final_is_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ofin) |-> (r_okind == mmst_pkg::KIND_TOTAL))
        else $error("final beat is not a total");

    a_idle_total_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOAD) |-> (r_total == '0))
        else $error("total not cleared between runs");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mmst_pkg::CNT_W'(mmst_pkg::MAX_CITIES))
        else $error("city count beyond capacity");

    a_union_distinct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        par_we && (r_state == S_UNION) |-> (par_waddr != par_wdata))
        else $error("union of a root with itself");

endmodule
